// File: hdl/as_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// as_pkg
// Shared constants, types and the key ordering function of the array sorter.
// ----------------------------------------------------------------------------
package as_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int KEY_W        = 32;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0]        count_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic    insert;
      logic    shift;
      logic    desc;
      key_type new_key;
   } cell_ctl_type;

   // True when key a must come strictly after key b in the selected order.
   function automatic logic goes_after(key_type a, key_type b, logic desc);
      goes_after = desc ? (a < b) : (a > b);
   endfunction

endpackage
`default_nettype wire

// File: hdl/as_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// as_cell
// One slot of the insertion chain: holds a key, takes the new key, its left
// neighbor's key or its right neighbor's key.
// ----------------------------------------------------------------------------
module as_cell
   import as_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire key_type      left_key,
   input  wire logic         left_valid,
   input  wire logic         left_ins,
   input  wire key_type      right_key,
   input  wire logic         right_valid,
   output key_type           key,
   output logic              valid,
   output logic              ins
);

   key_type key_ff, key_in;
   logic    valid_ff, valid_in;

   assign ins   = !valid_ff || goes_after(key_ff, ctl.new_key, ctl.desc);
   assign key   = key_ff;
   assign valid = valid_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.insert) begin
         if (ins && !left_ins) begin
            key_in   = ctl.new_key;
            valid_in = 1'b1;
         end else if (ins) begin
            key_in   = left_key;
            valid_in = left_valid;
         end
      end else if (ctl.shift) begin
         key_in   = right_key;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

// File: hdl/as_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// as_chain
// Row of insertion cells kept in sorted order; cell 0 is the head.
// ----------------------------------------------------------------------------
module as_chain
   import as_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cell_ctl_type            ctl,
   output key_type                      head_key,
   output logic [MAX_ELEMENTS-1:0]      valid_vec
);

   key_type                 keys [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] ins_vec;

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      key_type l_key, r_key;
      logic    l_valid, l_ins, r_valid;

      if (i == 0) begin : g_first
         assign l_key   = '0;
         assign l_valid = 1'b0;
         assign l_ins   = 1'b0;
      end else begin : g_mid_l
         assign l_key   = keys[i-1];
         assign l_valid = valid_vec[i-1];
         assign l_ins   = ins_vec[i-1];
      end

      if (i == MAX_ELEMENTS - 1) begin : g_last
         assign r_key   = '0;
         assign r_valid = 1'b0;
      end else begin : g_mid_r
         assign r_key   = keys[i+1];
         assign r_valid = valid_vec[i+1];
      end

      as_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_key    (l_key),
         .left_valid  (l_valid),
         .left_ins    (l_ins),
         .right_key   (r_key),
         .right_valid (r_valid),
         .key         (keys[i]),
         .valid       (valid_vec[i]),
         .ins         (ins_vec[i])
      );
   end

   assign head_key = keys[0];

endmodule
`default_nettype wire

// File: hdl/array_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_sorter
// Sorts a set of signed 32-bit keys in a chain of insertion cells.
// ----------------------------------------------------------------------------
// Keys of a set are taken one per cycle; each lands at its sorted place in a
// 64-cell insertion chain in the cycle it is transferred. After the key marked
// last, the set is shifted out of the chain head, one result per cycle while
// rsp_ready is high; req_ready is low while draining. The direction is sampled
// from the first key of a set. Keys beyond 64 are discarded and every result
// of that set carries overflow. The final result of a set stays in the output
// register while the next set loads.
module array_sorter
   import as_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire key_type req_key,
   input  wire logic    req_last,
   input  wire logic    req_descending,
   input  wire logic    req_valid,
   output logic         req_ready,
   output key_type      rsp_sorted_key,
   output logic         rsp_last_out,
   output logic         rsp_overflow,
   output logic         rsp_valid,
   input  wire logic    rsp_ready
);

   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   logic         dropped_ff, dropped_in;
   logic         order_ff, order_in;
   logic         rsp_valid_ff, rsp_valid_in;
   key_type      rsp_key_ff, rsp_key_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_ovf_ff, rsp_ovf_in;
   logic         pop;
   cell_ctl_type ctl;
   key_type      head_key;
   logic [MAX_ELEMENTS-1:0] valid_vec;

   as_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .head_key  (head_key),
      .valid_vec (valid_vec)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      order_in     = order_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_ready    = 1'b0;
      pop          = 1'b0;
      ctl.insert   = 1'b0;
      ctl.shift    = 1'b0;
      ctl.desc     = order_ff;
      ctl.new_key  = req_key;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff == '0) begin
                  order_in = req_descending;
               end
               if (count_ff != count_type'(MAX_ELEMENTS)) begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + count_type'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            pop = !rsp_valid_ff || rsp_ready;
            if (pop) begin
               ctl.shift    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_key_in   = head_key;
               rsp_last_in  = (count_ff == count_type'(1));
               rsp_ovf_in   = dropped_ff;
               count_in     = count_ff - count_type'(1);
               if (count_ff == count_type'(1)) begin
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_last_out   = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("kept count differs from occupied cells");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_ELEMENTS))
      else $error("kept count beyond capacity");

   a_drain_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> valid_vec[0])
      else $error("draining with empty chain head");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (pop && count_ff == count_type'(1)) |=> (count_ff == '0 && !dropped_ff
      && rsp_last_out))
      else $error("set end not cleaned up");
`endif

endmodule
`default_nettype wire
